// ===== hw/rtl/msps_pkg.sv =====
// Shared types and constants for the masked byte pattern scanner.
package msps_pkg;

    localparam int MAX_PATTERN_BYTES = 16;
    localparam int PATTERN_REG_BYTES = 16;
    localparam int LENGTH_CAP = (MAX_PATTERN_BYTES < PATTERN_REG_BYTES) ?
                                MAX_PATTERN_BYTES : PATTERN_REG_BYTES;

    localparam int DATA_W  = 8;
    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 5;
    localparam int ALIGN_W = 2;
    localparam int CARE_W  = 16;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 3;
    localparam int FILL_W  = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int WIN_W   = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_PATTERN_LOW      = 3'd0;
    localparam logic [IDX_W-1:0] REG_PATTERN_HIGH     = 3'd1;
    localparam logic [IDX_W-1:0] REG_CARE_MASK        = 3'd2;
    localparam logic [IDX_W-1:0] REG_PATTERN_LENGTH   = 3'd3;
    localparam logic [IDX_W-1:0] REG_ALIGNMENT        = 3'd4;
    localparam logic [IDX_W-1:0] REG_FIRST_MATCH_ONLY = 3'd5;

    // Reset values
    localparam logic [CARE_W-1:0] CARE_MASK_RESET      = 16'hffff;
    localparam logic [LEN_W-1:0]  PATTERN_LENGTH_RESET = 5'd4;

    typedef logic [MAX_PATTERN_BYTES-1:0][DATA_W-1:0] window_t;

    typedef struct packed {
        logic [2*CFG_W-1:0] pattern;   // byte i in bits 8*i+7 .. 8*i
        logic [CARE_W-1:0]  care_mask;
        logic [LEN_W-1:0]   pattern_length;
        logic [ALIGN_W-1:0] alignment;
        logic               first_match_only;
    } cfg_t;

    // Item held in the window stage
    typedef struct packed {
        logic              valid;
        logic              region_first;
        logic [ADDR_W-1:0] byte_address;
        logic [FILL_W-1:0] fill_count;
    } stage_t;

endpackage

// ===== hw/rtl/msps_cfg.sv =====
// Configuration register file of the pattern scanner.
module msps_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [msps_pkg::IDX_W-1:0]  cfg_index,
    input  logic [msps_pkg::CFG_W-1:0]  cfg_data,
    output msps_pkg::cfg_t              cfg
);
    import msps_pkg::*;

    logic [CFG_W-1:0]   pattern_low_reg;
    logic [CFG_W-1:0]   pattern_high_reg;
    logic [CARE_W-1:0]  care_mask_reg;
    logic [LEN_W-1:0]   pattern_length_reg;
    logic [ALIGN_W-1:0] alignment_reg;
    logic               first_match_only_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg      <= '0;
            pattern_high_reg     <= '0;
            care_mask_reg        <= CARE_MASK_RESET;
            pattern_length_reg   <= PATTERN_LENGTH_RESET;
            alignment_reg        <= '0;
            first_match_only_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PATTERN_LOW:      pattern_low_reg      <= cfg_data;
                REG_PATTERN_HIGH:     pattern_high_reg     <= cfg_data;
                REG_CARE_MASK:        care_mask_reg        <= cfg_data[CARE_W-1:0];
                REG_PATTERN_LENGTH:   pattern_length_reg   <= cfg_data[LEN_W-1:0];
                REG_ALIGNMENT:        alignment_reg        <= cfg_data[ALIGN_W-1:0];
                REG_FIRST_MATCH_ONLY: first_match_only_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg.pattern          = {pattern_high_reg, pattern_low_reg};
    assign cfg.care_mask        = care_mask_reg;
    assign cfg.pattern_length   = pattern_length_reg;
    assign cfg.alignment        = alignment_reg;
    assign cfg.first_match_only = first_match_only_reg;

endmodule

// ===== hw/rtl/msps_window.sv =====
// Input stage: byte window shift line, fill count and held item fields.
module msps_window
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic                          advance,
    input  logic [msps_pkg::DATA_W-1:0]   data_byte,
    input  logic [msps_pkg::ADDR_W-1:0]   byte_address,
    input  logic                          region_first,
    output msps_pkg::window_t             window,
    output msps_pkg::stage_t              stage
);
    import msps_pkg::*;

    window_t           window_reg;
    logic              valid_reg;
    logic              first_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_base;

    // Region start restarts the count; window contents are cleared with it
    assign fill_base = region_first ? '0 : fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            fill_reg   <= '0;
            valid_reg  <= 1'b0;
            first_reg  <= 1'b0;
            addr_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                if (region_first)
                    window_reg <= {{(MAX_PATTERN_BYTES-1)*DATA_W{1'b0}}, data_byte};
                else
                    window_reg <= {window_reg[MAX_PATTERN_BYTES-2:0], data_byte};
                if (fill_base < FILL_W'(MAX_PATTERN_BYTES))
                    fill_reg <= fill_base + FILL_W'(1);
                else
                    fill_reg <= fill_base;
                first_reg <= region_first;
                addr_reg  <= byte_address;
                valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign window             = window_reg;
    assign stage.valid        = valid_reg;
    assign stage.region_first = first_reg;
    assign stage.byte_address = addr_reg;
    assign stage.fill_count   = fill_reg;

endmodule

// ===== hw/rtl/msps_match.sv =====
// Masked window compare, alignment filter, result register.
module msps_match
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  msps_pkg::cfg_t                cfg,
    input  msps_pkg::window_t             window,
    input  msps_pkg::stage_t              stage,
    input  logic                          advance,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [msps_pkg::ADDR_W-1:0]   match_address
);
    import msps_pkg::*;

    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  sel;
    logic [ADDR_W-1:0] start;
    logic              byte_ok;
    logic              hit;
    logic              align_ok;
    logic              found_base;
    logic              report;
    logic              found_reg;
    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;

    always_comb
    begin
        if (cfg.pattern_length == '0)
            len = LEN_W'(1);
        else if (cfg.pattern_length > LEN_W'(LENGTH_CAP))
            len = LEN_W'(LENGTH_CAP);
        else
            len = cfg.pattern_length;
    end

    assign start = stage.byte_address - ADDR_W'(len - LEN_W'(1));

    always_comb
    begin
        if (cfg.alignment[1])
            align_ok = (start[1:0] == 2'b00);
        else if (cfg.alignment[0])
            align_ok = ~start[0];
        else
            align_ok = 1'b1;
    end

    // Pattern byte k lines up with the byte received len-1-k items ago
    always_comb
    begin
        hit = (stage.fill_count >= FILL_W'(len)) && align_ok;
        sel = '0;
        byte_ok = 1'b1;
        for (int k = 0; k < LENGTH_CAP; k++)
        begin
            sel = len - LEN_W'(1) - LEN_W'(k);
            byte_ok = (LEN_W'(k) >= len) || !cfg.care_mask[k] ||
                      (cfg.pattern[k*DATA_W +: DATA_W] == window[sel[WIN_W-1:0]]);
            hit = hit && byte_ok;
        end
    end

    assign found_base = stage.region_first ? 1'b0 : found_reg;
    assign report     = hit && !(cfg.first_match_only && found_base);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                found_reg     <= found_base | report;
                out_valid_reg <= report;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && report)
            out_addr_reg <= start;
    end

    assign m_tvalid      = out_valid_reg;
    assign match_address = out_addr_reg;

endmodule

// ===== hw/rtl/masked_byte_pattern_scanner_core.sv =====
// Top level of the masked byte pattern scanner.
//
// Scans a stream of address-tagged memory bytes for a pattern of up to 16
// bytes with per-byte care bits and reports the start address of each match
// whose window lies inside the current region and meets the selected
// alignment (optionally only the first match per region). One item is taken
// every cycle unless the result side stalls. The item carrying the last
// byte of the window is captured in the window register; the compare runs
// from there and the result register takes the match when the window
// stage advances, raising m_tvalid. Result backpressure stalls the window
// stage, dropping s_tready. The user must write configuration (cfg_wr_en,
// cfg_index, cfg_data) only while no item is in flight; nothing enforces it.
module masked_byte_pattern_scanner_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [msps_pkg::IDX_W-1:0]         cfg_index,
    input  logic [msps_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [msps_pkg::S_TDATA_W-1:0]     s_tdata,   // data_byte[7:0], byte_address[39:8]
    input  logic                               s_tuser,   // region_first
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [msps_pkg::M_TDATA_W-1:0]     m_tdata    // match_address[31:0]
);
    import msps_pkg::*;

    cfg_t    cfg;
    window_t window;
    stage_t  stage;
    logic    advance;
    logic    load;

    // Window stage moves on when the result register is free or draining
    assign advance  = stage.valid && (!m_tvalid || m_tready);
    assign s_tready = !stage.valid || advance;
    assign load     = s_tvalid && s_tready;

    msps_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    msps_window u_window
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .advance      (advance),
        .data_byte    (s_tdata[DATA_W-1:0]),
        .byte_address (s_tdata[DATA_W +: ADDR_W]),
        .region_first (s_tuser),
        .window       (window),
        .stage        (stage)
    );

    msps_match u_match
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .window        (window),
        .stage         (stage),
        .advance       (advance),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .match_address (m_tdata)
    );

endmodule
